// ===== hdl/fwrm_pkg.sv =====
package fwrm_pkg;

   // Field widths of the request and result transactions
   localparam int PUSH_BITS  = 16;
   localparam int MEAN_BITS  = 16;
   localparam int COUNT_BITS = 5;

   // Request codes; the fourth code is a no-op
   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [PUSH_BITS-1:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0]  mean_value;
      logic [COUNT_BITS-1:0] entry_count;
      logic                  push_dropped;
      logic                  queue_empty;
   } rsp_item_type;

endpackage

// ===== hdl/fwrm_ram.sv =====
module fwrm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fwrm_div.sv =====
module fwrm_div #(
   parameter int DIVIDEND_BITS = 20,
   parameter int DIVISOR_BITS  = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int SW  = DIVIDEND_BITS;
   localparam int CW  = DIVISOR_BITS;
   localparam int CNW = $clog2(SW + 1);

   logic [CW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  dvd_ff, dvd_in;
   logic [SW-1:0]  quo_ff, quo_in;
   logic [CW-1:0]  dvs_ff, dvs_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           active_ff, active_in;
   logic           done_ff, done_in;

   logic [CW:0] trial;
   logic [CW:0] diff;
   logic        fits;

   // Restoring step: shift in one dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[SW-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;

      if (start) begin
         rem_in    = '0;
         dvd_in    = dividend;
         quo_in    = '0;
         dvs_in    = divisor;
         cnt_in    = CNW'(SW);
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in = fits ? diff[CW-1:0] : trial[CW-1:0];
         dvd_in = {dvd_ff[SW-2:0], 1'b0};
         quo_in = {quo_ff[SW-2:0], fits};
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff    <= '0;
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/fifo_with_running_mean.sv =====
// Sequence: an accepted push, clear or no-op updates the queue state and then starts the
// divider; a pop of a held entry first reads the head word out of the store (ST_POP).
// Throughput: a new request is taken only once the previous result is out; busy stays high
// through the bit-serial divider, which takes one quotient bit per cycle over the running sum.
// Reset: synchronous, clears count, sum and pointers; stored entries are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module fifo_with_running_mean
   import fwrm_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_data,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = VALUE_BITS + $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_START,
      ST_WAIT
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          dropped_ff, dropped_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic                  accept;
   logic                  full;
   logic [31:0]           push_wide;
   logic [VALUE_BITS-1:0] value;
   logic                  wr_en;
   logic                  rd_en;
   logic [VALUE_BITS-1:0] rd_data;
   logic                  div_done;
   logic [SW-1:0]         div_quotient;
   logic [63:0]           mean_wide;
   logic [31:0]           count_wide;

   assign accept     = start && (state_ff == ST_IDLE);
   assign full       = (count_ff == CW'(DEPTH));
   assign push_wide  = 32'(req_data.push_value);
   assign value      = push_wide[VALUE_BITS-1:0];
   assign mean_wide  = 64'(div_quotient);
   assign count_wide = 32'(count_ff);

   // Store a push at the tail, fetch the head on a pop
   assign wr_en = accept && (req_data.req_type == REQ_PUSH) && !full;
   assign rd_en = accept && (req_data.req_type == REQ_POP) && (count_ff != '0);

   fwrm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (value),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   fwrm_div #(
      .DIVIDEND_BITS (SW),
      .DIVISOR_BITS  (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_START),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequence one transaction: update queue state, divide, report
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dropped_in = 1'b0;
               state_in   = ST_START;
               unique case (req_data.req_type)
                  REQ_PUSH: begin
                     if (full) begin
                        dropped_in = 1'b1;
                     end else begin
                        tail_in  = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
                        count_in = count_ff + CW'(1);
                        sum_in   = sum_ff + SW'(value);
                     end
                  end
                  REQ_POP: begin
                     if (count_ff != '0) begin
                        state_in = ST_POP;
                     end
                  end
                  REQ_CLEAR: begin
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                     sum_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            // Head word is now out of the store: drop it from the sum
            sum_in   = sum_ff - SW'(rd_data);
            head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in = count_ff - CW'(1);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               rsp_in.mean_value   = (count_ff == '0) ? '0 : mean_wide[MEAN_BITS-1:0];
               rsp_in.entry_count  = count_wide[COUNT_BITS-1:0];
               rsp_in.push_dropped = dropped_ff;
               rsp_in.queue_empty  = (count_ff == '0);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/fwrm_checker.sv =====
module fwrm_checker
   import fwrm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_data,
   input logic         rsp_valid,
   input rsp_item_type rsp_data
);

   // An accepted transaction keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   // A result comes only at the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe outside the end of a transaction");

   // One result per transaction: the strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An empty queue reports zero count and zero mean
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.queue_empty) |->
         (rsp_data.entry_count == '0 && rsp_data.mean_value == '0))
      else $error("empty queue reported a count or mean");

   // A dropped push means the queue was full, never empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.push_dropped) |-> !rsp_data.queue_empty)
      else $error("push dropped on an empty queue");

endmodule

bind fifo_with_running_mean fwrm_checker u_checker (.*);

// ===== bench/fifo_with_running_mean_tb.sv =====
module fifo_with_running_mean_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fwrm_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_REQS = 700;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 40;
   localparam int MAX_REPORTS = 200;

   // Request code the package leaves unnamed; the block treats it as a no-op
   localparam logic [1:0] REQ_NOP = 2'd3;

   // Queue model with running sum; holds the results still owed by the block
   class mean_scoreboard;
      logic [PUSH_BITS-1:0] slots [DEPTH];
      int unsigned head_slot;
      int unsigned tail_slot;
      int unsigned held;
      int unsigned total;
      rsp_item_type owed_rsp [$];
      int unsigned errors;

      function new();
         head_slot = 0;
         tail_slot = 0;
         held      = 0;
         total     = 0;
         errors    = 0;
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= MAX_REPORTS)
            $error("%s expected %0d actual %0d", field, want, got);
      endfunction

      // Apply one accepted request to the model and queue its result
      function void note_request(req_item_type item);
         rsp_item_type r;
         r.push_dropped = 1'b0;
         case (item.req_type)
            REQ_PUSH: begin
               if (held >= DEPTH) begin
                  r.push_dropped = 1'b1;
               end else begin
                  slots[tail_slot] = item.push_value;
                  tail_slot = (tail_slot + 1) % DEPTH;
                  held++;
                  total += item.push_value;
               end
            end
            REQ_POP: begin
               if (held != 0) begin
                  total -= slots[head_slot];
                  head_slot = (head_slot + 1) % DEPTH;
                  held--;
               end
            end
            REQ_CLEAR: begin
               head_slot = 0;
               tail_slot = 0;
               held      = 0;
               total     = 0;
            end
            default: begin
            end
         endcase
         r.mean_value  = (held != 0) ? MEAN_BITS'(total / held) : '0;
         r.entry_count = COUNT_BITS'(held);
         r.queue_empty = (held == 0);
         owed_rsp.push_back(r);
      endfunction

      // Compare one strobed result against the oldest owed one
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (owed_rsp.size() == 0) begin
            flag("unexpected result, mean_value", 'x, got.mean_value);
            return;
         end
         want = owed_rsp.pop_front();
         if (got.mean_value !== want.mean_value)
            flag("mean_value", want.mean_value, got.mean_value);
         if (got.entry_count !== want.entry_count)
            flag("entry_count", want.entry_count, got.entry_count);
         if (got.push_dropped !== want.push_dropped)
            flag("push_dropped", want.push_dropped, got.push_dropped);
         if (got.queue_empty !== want.queue_empty)
            flag("queue_empty", want.queue_empty, got.queue_empty);
      endfunction

      function int unsigned pending();
         return owed_rsp.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_data;
   logic         rsp_valid;
   rsp_item_type rsp_data;

   mean_scoreboard sb = new();
   int unsigned cycle_count = 0;
   bit burst_mode = 1'b0;

   fifo_with_running_mean u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Check results first, then note the transaction accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_data);
         if (start && !busy)
            sb.note_request(req_data);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Send one request; called and returns on a falling edge
   task automatic send_req(logic [1:0] code, logic [PUSH_BITS-1:0] value);
      int unsigned gap;
      if (!burst_mode && $urandom_range(0, 3) != 0)
         gap = $urandom_range(1, 7);
      else
         gap = 0;
      if ($urandom_range(0, 31) == 0)
         burst_mode = !burst_mode;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start               = 1'b1;
      req_data.req_type   = code;
      req_data.push_value = value;
      // busy only moves on a rising edge, so low here means the next edge accepts
      while (busy)
         @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [PUSH_BITS-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return PUSH_BITS'($urandom);
      endcase
   endfunction

   // Mostly push while filling and pop while draining, with clears and no-ops mixed in
   function automatic logic [1:0] pick_code(bit filling);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         return REQ_CLEAR;
      if (roll < 8)
         return REQ_NOP;
      if (roll < 76)
         return filling ? REQ_PUSH : REQ_POP;
      return filling ? REQ_POP : REQ_PUSH;
   endfunction

   initial begin
      bit filling;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty-queue cases, fill to full with the largest value,
      // drop on full, then pop and push across the pointer wrap
      send_req(REQ_CLEAR, 16'h1234);
      send_req(REQ_POP, 16'h0000);
      send_req(REQ_NOP, 16'hFFFF);
      repeat (DEPTH)
         send_req(REQ_PUSH, 16'hFFFF);
      send_req(REQ_PUSH, 16'h0000);
      send_req(REQ_NOP, 16'h0000);
      send_req(REQ_POP, 16'h0000);
      send_req(REQ_PUSH, 16'h0000);
      send_req(REQ_POP, 16'h5555);
      send_req(REQ_CLEAR, 16'hAAAA);

      // Random: alternate fill and drain phases so full and empty are both hit often
      filling = 1'b1;
      for (int i = 0; i < RANDOM_REQS; i++) begin
         if ($urandom_range(0, 39) == 0)
            filling = !filling;
         if (sb.held >= DEPTH && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if (sb.held == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
         send_req(pick_code(filling), pick_value());
      end
      start = 1'b0;

      // Let every owed result arrive, then watch for strays
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/fwrm_pkg.sv
hdl/fwrm_ram.sv
hdl/fwrm_div.sv
hdl/fifo_with_running_mean.sv
hdl/fwrm_checker.sv
bench/fifo_with_running_mean_tb.sv
